// ===== hdl/abr_pkg.sv =====
// Shared types, constants and helper functions for the audio block ring.
package abr_pkg;

    // Default sizes handed to the top level.
    localparam int RING_SLOTS_DEF = 8;
    localparam int BLOCK_MAX_DEF  = 2048;
    localparam int RAMP_LEN_DEF   = 64;

    // Block lengths selected by the block size register.
    localparam int BLK_LEN_0 = 1024;
    localparam int BLK_LEN_1 = 1536;
    localparam int BLK_LEN_2 = 2048;

    // Rate controller constants.
    localparam int NOMINAL_HZ    = 44100;
    localparam int GAIN_P        = 4000;
    localparam int GAIN_I        = 90;
    localparam int PPM_SCALE     = 1000000;
    localparam int PPM_LIM_1     = 10000;
    localparam int PPM_LIM_2     = 30000;
    localparam int PPM_LIM_3     = 150000;
    localparam int FREERUN_DEPTH = 4;
    // 44100 / 1000000 reduced to 441 / 10000 keeps the division exact.
    localparam int PITCH_NUM     = NOMINAL_HZ / 100;
    localparam int PITCH_DEN     = PPM_SCALE / 100;

    // Occupancy width seen by the rate controller; covers up to 16 slots.
    localparam int OCC_W = 5;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE = 2'd0,
        CFG_RING_DEPTH = 2'd1,
        CFG_RATE_MODE  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BLK_SEL_1024 = 2'd0,
        BLK_SEL_1536 = 2'd1,
        BLK_SEL_2048 = 2'd2
    } t_blk_sel;

    typedef enum logic [1:0] {
        RATE_OFF = 2'd0,
        RATE_1PC = 2'd1,
        RATE_3PC = 2'd2,
        RATE_15PC = 2'd3
    } t_rate_mode;

    typedef enum logic [1:0] {
        MODE_REAL    = 2'd0,
        MODE_FADE    = 2'd1,
        MODE_CONCEAL = 2'd2
    } t_play_mode;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] in_left;
        logic signed [15:0] in_right;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic               concealing;
        logic               dropping;
        logic               ring_full;
        logic [3:0]         occupancy;
        logic [15:0]        pitch_hz;
    } t_out_word;

    typedef struct packed {
        logic             start;
        logic [OCC_W-1:0] used;
        logic [OCC_W-1:0] limit;
        logic [1:0]       mode;
    } t_rate_req;

    function automatic logic [17:0] max_ppm(input logic [1:0] mode);
        logic [17:0] v;
        unique case (t_rate_mode'(mode))
            RATE_OFF:  v = '0;
            RATE_1PC:  v = 18'(PPM_LIM_1);
            RATE_3PC:  v = 18'(PPM_LIM_2);
            RATE_15PC: v = 18'(PPM_LIM_3);
            default:   v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [10:0] int_limit(input logic [1:0] mode);
        logic [10:0] v;
        unique case (t_rate_mode'(mode))
            RATE_OFF:  v = '0;
            RATE_1PC:  v = 11'(PPM_LIM_1 / GAIN_I);
            RATE_3PC:  v = 11'(PPM_LIM_2 / GAIN_I);
            RATE_15PC: v = 11'(PPM_LIM_3 / GAIN_I);
            default:   v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] abs16(input logic signed [15:0] x);
        logic [15:0] v;
        v = x[15] ? 16'(-x) : 16'(x);
        return v;
    endfunction

endpackage

// ===== hdl/abr_stream_if.sv =====
// Valid/ready stream interface that carries one word per handshake.
interface abr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/abr_sample_mem.sv =====
// Sample store: one write port and one read port with registered read data.
module abr_sample_mem #(
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [31:0]       i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [31:0]       o_rdata
);
    logic [31:0] r_mem [2**ADDR_W];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/abr_rate_ctrl.sv =====
// PI pitch controller on ring occupancy, run once per playback block.
module abr_rate_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  abr_pkg::t_rate_req i_req,
    output logic              o_busy,
    output logic [15:0]       o_pitch
);
    import abr_pkg::*;

    localparam int YW         = 26;
    localparam int PitchShift = YW + $clog2(PITCH_DEN);
    localparam logic [63:0] PitchMulL =
        ((64'd1 << PitchShift) + 64'(PITCH_DEN) - 64'd1) / 64'(PITCH_DEN);
    localparam int MulW = 27;
    localparam logic [MulW-1:0] PitchMul = PitchMulL[MulW-1:0];

    typedef enum logic [2:0] {R_IDLE, R_PI, R_SCALE, R_DIV, R_APPLY} t_state;

    t_state             r_state;
    logic signed [11:0] r_integral;
    logic [15:0]        r_pitch;
    logic [OCC_W-1:0]   r_used;
    logic [OCC_W-1:0]   r_limit;
    logic [1:0]         r_mode;
    logic [17:0]        r_ppm_mag;
    logic               r_neg;
    logic [YW-1:0]      r_y;
    logic [15:0]        r_q;

    logic signed [6:0]    err;
    logic signed [12:0]   ilim;
    logic signed [12:0]   isum;
    logic signed [11:0]   n_integral;
    logic signed [20:0]   pmax;
    logic signed [20:0]   ppm;
    logic signed [20:0]   ppm_c;
    logic [YW+MulW-1:0]   prod;
    logic [16:0]          cand;
    logic                 take;

    always_comb begin
        err  = $signed({1'b0, r_used, 1'b0}) - $signed({2'b00, r_limit});
        ilim = $signed(13'(int_limit(r_mode)));
        isum = 13'(r_integral) + 13'(err);
        if (isum > ilim) begin
            n_integral = 12'(ilim);
        end else if (isum < -ilim) begin
            n_integral = 12'(-ilim);
        end else begin
            n_integral = 12'(isum);
        end
        pmax = $signed(21'(max_ppm(r_mode)));
        ppm  = 21'(err) * $signed(21'(GAIN_P)) + 21'(n_integral) * $signed(21'(GAIN_I));
        if (ppm > pmax) begin
            ppm_c = pmax;
        end else if (ppm < -pmax) begin
            ppm_c = -pmax;
        end else begin
            ppm_c = ppm;
        end
        prod = YW'(r_y) * PitchMul;
        cand = r_neg ? 17'(NOMINAL_HZ) - 17'(r_q) : 17'(NOMINAL_HZ) + 17'(r_q);
        take = (cand > {1'b0, r_pitch} + 17'd1) || (cand + 17'd1 < {1'b0, r_pitch});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= R_IDLE;
            r_integral <= '0;
            r_pitch    <= 16'(NOMINAL_HZ);
        end else begin
            unique case (r_state)
                R_IDLE: begin
                    if (i_req.start) begin
                        r_used  <= i_req.used;
                        r_limit <= i_req.limit;
                        r_mode  <= i_req.mode;
                        r_state <= R_PI;
                    end
                end
                R_PI: begin
                    if (t_rate_mode'(r_mode) == RATE_OFF) begin
                        // Rate control off: snap back to nominal once.
                        if (r_pitch != 16'(NOMINAL_HZ)) begin
                            r_pitch    <= 16'(NOMINAL_HZ);
                            r_integral <= '0;
                        end
                        r_state <= R_IDLE;
                    end else begin
                        r_integral <= n_integral;
                        r_neg      <= ppm_c[20];
                        r_ppm_mag  <= ppm_c[20] ? 18'(-ppm_c) : 18'(ppm_c);
                        r_state    <= R_SCALE;
                    end
                end
                R_SCALE: begin
                    r_y     <= YW'(r_ppm_mag * 9'(PITCH_NUM));
                    r_state <= R_DIV;
                end
                R_DIV: begin
                    r_q     <= prod[PitchShift +: 16];
                    r_state <= R_APPLY;
                end
                R_APPLY: begin
                    // Changes of one hertz or less are not taken.
                    if (take) begin
                        r_pitch <= cand[15:0];
                    end
                    r_state <= R_IDLE;
                end
                default: r_state <= R_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != R_IDLE);
    assign o_pitch = r_pitch;
endmodule

// ===== hdl/audio_block_ring_with_rate_control.sv =====
// Top level of the audio block ring with occupancy-driven pitch control.
//
//   channel    dir  handshake         word
//   i_sample   in   valid / ready     kind, in_left, in_right
//   o_result   out  valid / ready     out_left, out_right, flags, occupancy, pitch
//   i_cfg_*    in   write enable      register index, data
//
// A push word is executed in the cycle it is accepted, and its result passes from the
// hold state into the output register. A pull word passes the sample memory read, the
// ramp multiply and divide-by-constant (S_MUL1, S_MUL2), a finish step and the output
// load. At the start of a playback block the PI controller runs four steps (one when rate
// control is off) beside the ramp path and holds the finish step until it is idle.
// Reset is synchronous and clears all control state; the sample memory is not cleared.
// The input is not ready while a word is in work; a stalled output holds the last word
// in the hold state until the output register frees the earlier word.
module audio_block_ring_with_rate_control #(
    parameter int RING_SLOTS = abr_pkg::RING_SLOTS_DEF,
    parameter int BLOCK_MAX  = abr_pkg::BLOCK_MAX_DEF,
    parameter int RAMP_LEN   = abr_pkg::RAMP_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [abr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [abr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    abr_stream_if.sink                     i_sample,
    abr_stream_if.source                   o_result
);
    import abr_pkg::*;

    localparam int SlotW = $clog2(RING_SLOTS);
    localparam int PosW  = $clog2(BLOCK_MAX);
    localparam int LenW  = PosW + 1;
    localparam int CntW  = $clog2(RING_SLOTS + 1);
    localparam int AddrW = SlotW + PosW;
    localparam int KW    = $clog2(RAMP_LEN + 1);
    localparam int MagW  = 16 + KW;
    localparam int MulW  = MagW + 2;
    localparam int RampShift = MagW + $clog2(RAMP_LEN);
    localparam logic [63:0] RampMulL =
        ((64'd1 << RampShift) + 64'(RAMP_LEN) - 64'd1) / 64'(RAMP_LEN);
    localparam logic [MulW-1:0] RampMul = RampMulL[MulW-1:0];
    localparam int Len0 = (BLK_LEN_0 > BLOCK_MAX) ? BLOCK_MAX : BLK_LEN_0;
    localparam int Len1 = (BLK_LEN_1 > BLOCK_MAX) ? BLOCK_MAX : BLK_LEN_1;
    localparam int Len2 = (BLK_LEN_2 > BLOCK_MAX) ? BLOCK_MAX : BLK_LEN_2;
    localparam int FreeDepth = (FREERUN_DEPTH > RING_SLOTS) ? RING_SLOTS : FREERUN_DEPTH;

    typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_FIN, S_HOLD} t_state;

    // Configuration registers.
    logic [1:0] r_block_size;
    logic [3:0] r_depth;
    logic [1:0] r_rate_mode;

    // Ring control state.
    t_state             r_state;
    logic [SlotW-1:0]   r_write_slot;
    logic [SlotW-1:0]   r_read_slot;
    logic [CntW-1:0]    r_count;
    logic [PosW-1:0]    r_fill;
    logic               r_slot_free;
    logic [PosW-1:0]    r_play_pos;
    t_play_mode         r_play_mode;
    logic               r_fade_pend;
    logic signed [15:0] r_held_l;
    logic signed [15:0] r_held_r;

    // Pull datapath.
    logic signed [15:0] r_raw_l;
    logic signed [15:0] r_raw_r;
    logic [MagW-1:0]    r_mag_l;
    logic [MagW-1:0]    r_mag_r;
    logic               r_neg_l;
    logic               r_neg_r;
    logic               r_in_ramp;
    logic [15:0]        r_q_l;
    logic [15:0]        r_q_r;

    t_out_word r_res;
    t_out_word r_out;
    logic      r_ovalid;

    logic [LenW-1:0]  cur_len;
    logic [CntW-1:0]  limit;
    logic [CntW-1:0]  depth_c;
    logic             accept;
    logic             is_pull;
    logic             mem_we;
    logic             mem_re;
    logic [AddrW-1:0] mem_waddr;
    logic [AddrW-1:0] mem_raddr;
    logic [31:0]      mem_wdata;
    logic [31:0]      mem_rdata;
    t_rate_req        rate_req;
    logic             rate_busy;
    logic [15:0]      pitch;

    // Push path.
    logic             sf_eff;
    logic [PosW:0]    fill_inc;
    logic             push_end;
    logic [CntW-1:0]  n_push_cnt;
    logic             n_push_sf;
    logic [SlotW-1:0] ws_inc;

    // Pull path.
    logic               conceal;
    logic signed [15:0] raw_l;
    logic signed [15:0] raw_r;
    logic signed [15:0] base_l;
    logic signed [15:0] base_r;
    logic [KW-1:0]      k;
    logic               in_ramp;
    logic [MagW+MulW-1:0] prod_l;
    logic [MagW+MulW-1:0] prod_r;
    logic signed [15:0] sc_l;
    logic signed [15:0] sc_r;
    logic signed [15:0] n_out_l;
    logic signed [15:0] n_out_r;
    logic [PosW:0]      play_inc;
    logic               pull_end;
    logic [CntW-1:0]    n_pull_cnt;
    logic [SlotW-1:0]   rs_inc;

    always_comb begin
        unique case (t_blk_sel'(r_block_size))
            BLK_SEL_1536: cur_len = LenW'(Len1);
            BLK_SEL_2048: cur_len = LenW'(Len2);
            default:      cur_len = LenW'(Len0);
        endcase
        // Free-run uses a fixed depth; a paced depth above the slot count saturates.
        depth_c = (r_depth == 4'd0) ? CntW'(FreeDepth) : CntW'(r_depth);
        if ({1'b0, r_depth} > 5'(RING_SLOTS)) begin
            limit = CntW'(RING_SLOTS);
        end else begin
            limit = depth_c;
        end
    end

    assign accept  = i_sample.valid && (r_state == S_IDLE);
    assign is_pull = (i_sample.data.kind == KIND_PULL);
    assign i_sample.ready = (r_state == S_IDLE);

    // Push: in paced mode the first sample of a block checks for room again.
    always_comb begin
        sf_eff   = ((r_fill == '0) && (r_depth != 4'd0)) ? (r_count < limit) : r_slot_free;
        fill_inc = {1'b0, r_fill} + 1'b1;
        push_end = (fill_inc >= (PosW + 1)'(cur_len));
        ws_inc   = (r_write_slot == SlotW'(RING_SLOTS - 1)) ? '0 : r_write_slot + 1'b1;
        if (push_end && sf_eff && (r_count < CntW'(RING_SLOTS))) begin
            n_push_cnt = r_count + 1'b1;
        end else begin
            n_push_cnt = r_count;
        end
        n_push_sf = push_end ? (n_push_cnt < limit) : sf_eff;
    end

    assign mem_we    = accept && !is_pull && sf_eff;
    assign mem_waddr = {r_write_slot, r_fill};
    assign mem_wdata = {i_sample.data.in_right, i_sample.data.in_left};
    assign mem_re    = accept && is_pull;
    assign mem_raddr = {r_read_slot, r_play_pos};

    abr_sample_mem #(
        .ADDR_W (AddrW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        rate_req.start = accept && is_pull && (r_play_pos == '0);
        rate_req.used  = OCC_W'(r_count);
        rate_req.limit = OCC_W'(limit);
        rate_req.mode  = r_rate_mode;
    end

    abr_rate_ctrl u_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rate_req),
        .o_busy  (rate_busy),
        .o_pitch (pitch)
    );

    // Pull: the ramp gain is either the distance to the ramp end (concealment) or the
    // position itself (fade-in); the division by the ramp length is a reciprocal
    // multiply that is exact over the whole magnitude range.
    always_comb begin
        conceal = (r_play_mode == MODE_CONCEAL);
        raw_l   = $signed(mem_rdata[15:0]);
        raw_r   = $signed(mem_rdata[31:16]);
        base_l  = conceal ? r_held_l : raw_l;
        base_r  = conceal ? r_held_r : raw_r;
        in_ramp = (r_play_pos < PosW'(RAMP_LEN));
        k       = conceal ? KW'(RAMP_LEN) - KW'(r_play_pos) : KW'(r_play_pos);
        prod_l  = MagW'(r_mag_l) * RampMul;
        prod_r  = MagW'(r_mag_r) * RampMul;
        sc_l    = r_neg_l ? -$signed(r_q_l) : $signed(r_q_l);
        sc_r    = r_neg_r ? -$signed(r_q_r) : $signed(r_q_r);
        if (conceal) begin
            n_out_l = r_in_ramp ? sc_l : '0;
            n_out_r = r_in_ramp ? sc_r : '0;
        end else if ((r_play_mode == MODE_FADE) && r_in_ramp) begin
            n_out_l = sc_l;
            n_out_r = sc_r;
        end else begin
            n_out_l = r_raw_l;
            n_out_r = r_raw_r;
        end
        play_inc = {1'b0, r_play_pos} + 1'b1;
        pull_end = (play_inc >= (PosW + 1)'(cur_len));
        rs_inc   = (r_read_slot == SlotW'(RING_SLOTS - 1)) ? '0 : r_read_slot + 1'b1;
        if (pull_end && !conceal && (r_count != '0)) begin
            n_pull_cnt = r_count - 1'b1;
        end else begin
            n_pull_cnt = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= '0;
            r_depth      <= '0;
            r_rate_mode  <= '0;
            r_state      <= S_IDLE;
            r_write_slot <= '0;
            r_read_slot  <= '0;
            r_count      <= '0;
            r_fill       <= '0;
            r_slot_free  <= 1'b1;
            r_play_pos   <= '0;
            r_play_mode  <= MODE_REAL;
            r_fade_pend  <= 1'b0;
            r_held_l     <= '0;
            r_held_r     <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_BLOCK_SIZE: r_block_size <= i_cfg_data[1:0];
                    CFG_RING_DEPTH: r_depth      <= i_cfg_data;
                    CFG_RATE_MODE:  r_rate_mode  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            if (r_ovalid && o_result.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && !is_pull) begin
                        if (push_end) begin
                            r_fill <= '0;
                            if (sf_eff) begin
                                r_write_slot <= ws_inc;
                            end
                        end else begin
                            r_fill <= fill_inc[PosW-1:0];
                        end
                        r_count               <= n_push_cnt;
                        r_slot_free           <= n_push_sf;
                        r_res.out_left        <= '0;
                        r_res.out_right       <= '0;
                        r_res.concealing      <= 1'b0;
                        r_res.dropping        <= !n_push_sf;
                        r_res.ring_full       <= (n_push_cnt >= limit);
                        r_res.occupancy       <= 4'(n_push_cnt);
                        r_res.pitch_hz        <= pitch;
                        r_state               <= S_HOLD;
                    end else if (accept) begin
                        // Block start: take the oldest slot or begin concealment.
                        if (r_play_pos == '0) begin
                            if (r_count != '0) begin
                                r_play_mode <= r_fade_pend ? MODE_FADE : MODE_REAL;
                                r_fade_pend <= 1'b0;
                            end else begin
                                r_play_mode <= MODE_CONCEAL;
                                r_fade_pend <= 1'b1;
                            end
                        end
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_raw_l   <= raw_l;
                    r_raw_r   <= raw_r;
                    r_neg_l   <= base_l[15];
                    r_neg_r   <= base_r[15];
                    r_mag_l   <= abs16(base_l) * k;
                    r_mag_r   <= abs16(base_r) * k;
                    r_in_ramp <= in_ramp;
                    r_state   <= S_MUL2;
                end
                S_MUL2: begin
                    r_q_l   <= prod_l[RampShift +: 16];
                    r_q_r   <= prod_r[RampShift +: 16];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // The pitch of a block-start word is final once the controller is idle.
                    if (!rate_busy) begin
                        if (!conceal && pull_end) begin
                            r_held_l <= r_raw_l;
                            r_held_r <= r_raw_r;
                        end
                        if (pull_end) begin
                            r_play_pos <= '0;
                            if (conceal) begin
                                r_held_l <= '0;
                                r_held_r <= '0;
                            end else begin
                                r_read_slot <= rs_inc;
                            end
                        end else begin
                            r_play_pos <= play_inc[PosW-1:0];
                        end
                        r_count          <= n_pull_cnt;
                        r_res.out_left   <= n_out_l;
                        r_res.out_right  <= n_out_r;
                        r_res.concealing <= conceal;
                        r_res.dropping   <= 1'b0;
                        r_res.ring_full  <= (n_pull_cnt >= limit);
                        r_res.occupancy  <= 4'(n_pull_cnt);
                        r_res.pitch_hz   <= pitch;
                        r_state          <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (!r_ovalid || o_result.ready) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid = r_ovalid;
    assign o_result.data  = r_out;

    // Published blocks never exceed the slot count.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(RING_SLOTS))
        else $error("ring occupancy above slot count");

    // The write slot leads the read slot by exactly the occupancy, modulo the ring size.
    a_slot_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((SlotW + CntW)'(r_read_slot) + (SlotW + CntW)'(r_count)
            == (SlotW + CntW)'(r_write_slot)) ||
        ((SlotW + CntW)'(r_read_slot) + (SlotW + CntW)'(r_count)
            == (SlotW + CntW)'(r_write_slot) + (SlotW + CntW)'(RING_SLOTS)))
        else $error("read and write slots out of step with occupancy");

    // A pull word never finishes while the pitch controller is still working.
    a_fin_waits_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && rate_busy) |=> (r_state == S_FIN))
        else $error("pull word finished before pitch update");
endmodule

// ===== verif/audio_block_ring_with_rate_control_checker.sv =====
// Checker for the audio block ring: predicts every result word and compares it field by field.
module audio_block_ring_with_rate_control_checker
    import abr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_word              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_word             i_out_data,
    output int                    o_mismatches,
    output int                    o_waiting,
    output int                    o_fill_pos,
    output int                    o_play_pos,
    output int                    o_blocks
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_WORDS = RING_SLOTS_DEF * BLOCK_MAX_DEF;

    logic [31:0] sample_mem [STORE_WORDS];
    int          wr_slot, rd_slot, blocks, fill_pos, play_pos;
    bit          slot_free, fade_pending;
    t_play_mode  play_mode;
    int          held_l, held_r, integ, pitch;
    int          size_sel, depth;
    t_rate_mode  rate;
    t_out_word   expected_words [$];

    function automatic int block_len();
        int n;
        case (size_sel)
            1:       n = BLK_LEN_1;
            2:       n = BLK_LEN_2;
            default: n = BLK_LEN_0;
        endcase
        return (n > BLOCK_MAX_DEF) ? BLOCK_MAX_DEF : n;
    endfunction

    function automatic int occ_limit();
        int d;
        d = (depth != 0) ? depth : FREERUN_DEPTH;
        return (d > RING_SLOTS_DEF) ? RING_SLOTS_DEF : d;
    endfunction

    function automatic void retune_pitch(input int used);
        int mx, err, lim, ppm, p;
        case (rate)
            RATE_1PC:  mx = PPM_LIM_1;
            RATE_3PC:  mx = PPM_LIM_2;
            RATE_15PC: mx = PPM_LIM_3;
            default:   mx = 0;
        endcase
        if (mx == 0) begin
            if (pitch != NOMINAL_HZ) begin
                pitch = NOMINAL_HZ;
                integ = 0;
            end
            return;
        end
        err = used * 2 - occ_limit();
        lim = mx / GAIN_I;
        integ += err;
        if (integ > lim) integ = lim;
        if (integ < -lim) integ = -lim;
        ppm = err * GAIN_P + integ * GAIN_I;
        if (ppm > mx) ppm = mx;
        if (ppm < -mx) ppm = -mx;
        p = NOMINAL_HZ + int'((longint'(NOMINAL_HZ) * ppm) / PPM_SCALE);
        if (p > pitch + 1 || p < pitch - 1) pitch = p;
    endfunction

    function automatic void push_sample(input logic signed [15:0] l, input logic signed [15:0] r);
        int len;
        len = block_len();
        if (fill_pos == 0 && depth != 0) slot_free = blocks < occ_limit();
        if (slot_free && fill_pos < BLOCK_MAX_DEF)
            sample_mem[wr_slot * BLOCK_MAX_DEF + fill_pos] = {r, l};
        fill_pos++;
        if (fill_pos < len) return;
        fill_pos = 0;
        if (slot_free) begin
            wr_slot = (wr_slot + 1) % RING_SLOTS_DEF;
            if (blocks < RING_SLOTS_DEF) blocks++;
        end
        slot_free = blocks < occ_limit();
    endfunction

    function automatic void pull_sample(output int l, output int r);
        int          len, n;
        logic [31:0] w;
        len = block_len();
        n = (len < RAMP_LEN_DEF) ? len : RAMP_LEN_DEF;
        l = 0;
        r = 0;
        if (play_pos == 0) begin
            if (blocks != 0) begin
                play_mode = fade_pending ? MODE_FADE : MODE_REAL;
                fade_pending = 0;
            end else begin
                play_mode = MODE_CONCEAL;
                fade_pending = 1;
            end
            retune_pitch(blocks);
        end
        if (play_mode == MODE_CONCEAL) begin
            // Ramp from the held sample down to silence.
            if (play_pos < n) begin
                l = (held_l * (n - play_pos)) / n;
                r = (held_r * (n - play_pos)) / n;
            end
        end else begin
            w = (play_pos < BLOCK_MAX_DEF) ? sample_mem[rd_slot * BLOCK_MAX_DEF + play_pos] : '0;
            l = int'($signed(w[15:0]));
            r = int'($signed(w[31:16]));
            if (play_pos + 1 >= len) begin
                held_l = l;
                held_r = r;
            end
            if (play_mode == MODE_FADE && play_pos < n) begin
                l = (l * play_pos) / n;
                r = (r * play_pos) / n;
            end
        end
        play_pos++;
        if (play_pos >= len) begin
            play_pos = 0;
            if (play_mode == MODE_CONCEAL) begin
                held_l = 0;
                held_r = 0;
            end else begin
                rd_slot = (rd_slot + 1) % RING_SLOTS_DEF;
                if (blocks > 0) blocks--;
            end
        end
    endfunction

    function automatic t_out_word predict_ring_word(input t_in_word w);
        t_out_word o;
        int        l, r;
        o = '0;
        if (w.kind == KIND_PULL) begin
            pull_sample(l, r);
            o.out_left   = 16'(l);
            o.out_right  = 16'(r);
            o.concealing = (play_mode == MODE_CONCEAL);
        end else begin
            push_sample(w.in_left, w.in_right);
            o.dropping = !slot_free;
        end
        o.ring_full = blocks >= occ_limit();
        o.occupancy = 4'(blocks);
        o.pitch_hz  = 16'(pitch);
        return o;
    endfunction

    initial o_mismatches = 0;

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            wr_slot = 0; rd_slot = 0; blocks = 0; fill_pos = 0; slot_free = 1;
            play_pos = 0; play_mode = MODE_REAL; fade_pending = 0;
            held_l = 0; held_r = 0; integ = 0; pitch = NOMINAL_HZ;
            size_sel = 0; depth = 0; rate = RATE_OFF;
            expected_words.delete();
        end else begin
            // Compare before queuing, so a word accepted at this edge never matches itself.
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("%t result word with nothing expected: %p", $realtime, i_out_data);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.out_left !== i_out_data.out_left
                        || exp_w.out_right !== i_out_data.out_right
                        || exp_w.concealing !== i_out_data.concealing
                        || exp_w.dropping !== i_out_data.dropping
                        || exp_w.ring_full !== i_out_data.ring_full
                        || exp_w.occupancy !== i_out_data.occupancy
                        || exp_w.pitch_hz !== i_out_data.pitch_hz) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("%t mismatch: expected %p, got %p",
                                     $realtime, exp_w, i_out_data);
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BLOCK_SIZE: size_sel = int'(i_cfg_data[1:0]);
                    CFG_RING_DEPTH: depth = int'(i_cfg_data);
                    CFG_RATE_MODE:  rate = t_rate_mode'(i_cfg_data[1:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_words.push_back(predict_ring_word(i_in_data));
        end
        o_waiting  = expected_words.size();
        o_fill_pos = fill_pos;
        o_play_pos = play_pos;
        o_blocks   = blocks;
    end
endmodule

// ===== verif/audio_block_ring_with_rate_control_test.sv =====
// Top of the audio block ring test: clock, reset, stimulus, configuration and the verdict.
module audio_block_ring_with_rate_control_test;
    import abr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The block size register also takes the unused selector, which must act as 1024.
    localparam logic [3:0] BLK_SEL_UNUSED = 4'd3;
    localparam int PHASE_WORDS  = 2800;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_AT      = 3500;
    localparam int HOLD_CYCLES  = 600;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    abr_stream_if #(.T(t_in_word))  sample_ch ();
    abr_stream_if #(.T(t_out_word)) result_ch ();

    int  mismatches, waiting, fill_pos, play_pos, blocks;
    int  cur_len;
    bit  calm;
    int  idle_cycles;
    int  results_taken;

    audio_block_ring_with_rate_control u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (sample_ch),
        .o_result   (result_ch)
    );

    // The checker sits beside the block and sees both channels and the register port.
    audio_block_ring_with_rate_control_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (sample_ch.valid),
        .i_in_ready   (sample_ch.ready),
        .i_in_data    (sample_ch.data),
        .i_out_valid  (result_ch.valid),
        .i_out_ready  (result_ch.ready),
        .i_out_data   (result_ch.data),
        .o_mismatches (mismatches),
        .o_waiting    (waiting),
        .o_fill_pos   (fill_pos),
        .o_play_pos   (play_pos),
        .o_blocks     (blocks)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Most gaps are short, a few are long, and calm bursts have none at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Sample values lean on the extremes now and then; the rest are fully random.
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one word after a random gap and returns at the edge where it is accepted.
    // A valid that stays high for the next word is never lowered in between.
    task automatic send_word(input logic kind, input logic signed [15:0] l,
                             input logic signed [15:0] r);
        int       gap;
        t_in_word w;
        gap = pick_gap();
        w.kind = kind;
        w.in_left = l;
        w.in_right = r;
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= w;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
    endtask

    // Drops valid, waits for every expected word, then lets the pipeline run dry.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (waiting != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [3:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Before the block length is raised, the producer must stand at a block start and the
    // ring must be empty, otherwise playback would read slot entries that were never written.
    task automatic align_ring();
        int n;
        settle();
        if (fill_pos != 0) begin
            n = (fill_pos >= cur_len) ? 1 : cur_len - fill_pos;
            repeat (n) send_word(KIND_PUSH, pick_sample(), pick_sample());
            settle();
        end
        n = ((play_pos != 0) ? cur_len - play_pos : 0) + blocks * cur_len;
        repeat (n) send_word(KIND_PULL, pick_sample(), pick_sample());
        settle();
    endtask

    // Bursts of pushes and pulls swing the occupancy between underrun and full; long
    // bursts cross block boundaries, short ones mix the two sides closely.
    task automatic run_traffic(input int words, input int push_pct);
        int   sent, burst;
        logic kind;
        sent = 0;
        while (sent < words) begin
            kind  = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_PULL;
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 1100)
                                                : $urandom_range(1, 40);
            calm  = ($urandom_range(0, 3) == 0);
            repeat (burst) begin
                send_word(kind, pick_sample(), pick_sample());
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    // Receiver: random stalls, and once a long hold so that the ring backs up into the input.
    initial begin
        int  stall;
        bit  held;
        stall = 0;
        held  = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_ch.valid && result_ch.ready) results_taken++;
            if (!held && results_taken >= HOLD_AT) begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall > 0) begin
                result_ch.ready <= 1'b0;
                stall--;
            end else begin
                result_ch.ready <= 1'b1;
                case ($urandom_range(0, 19))
                    0:       stall = $urandom_range(10, 40);
                    1, 2, 3: stall = $urandom_range(1, 3);
                    default: stall = calm ? 0 : ($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("FAIL audio_block_ring_with_rate_control");
            $finish;
        end
    end

    initial begin
        results_taken = 0;
        idle_cycles   = 0;
        calm          = 1'b0;
        cur_len       = BLK_LEN_0;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_BLOCK_SIZE;
        cfg_data        <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Pulls right after reset find an empty ring and must conceal with silence.
        repeat (3) send_word(KIND_PULL, 16'sh7fff, 16'sh8000);
        // Pushes with the extremes of both channels, then pulls that keep concealing.
        send_word(KIND_PUSH, 16'sh7fff, 16'sh8000);
        send_word(KIND_PUSH, 16'sh8000, 16'sh7fff);
        send_word(KIND_PUSH, 16'sh0000, 16'sh0000);
        send_word(KIND_PUSH, -16'sd1, 16'sd1);
        send_word(KIND_PUSH, 16'sd1, -16'sd1);
        send_word(KIND_PUSH, 16'sh5555, 16'shaaaa);
        send_word(KIND_PUSH, 16'shaaaa, 16'sh5555);
        repeat (4) send_word(KIND_PULL, 16'sh0000, 16'sh0000);
        send_word(KIND_PUSH, 16'sh7fff, 16'sh7fff);
        send_word(KIND_PUSH, 16'sh8000, 16'sh8000);
        settle();

        // Free-running ring with the widest pitch range.
        cfg_write(CFG_BLOCK_SIZE, 4'(BLK_SEL_1024));
        cfg_write(CFG_RING_DEPTH, 4'd0);
        cfg_write(CFG_RATE_MODE, 4'(RATE_15PC));
        run_traffic(PHASE_WORDS, 55);
        settle();

        // Paced with a two-slot limit and the unused size selector; the long receiver
        // hold falls in this phase.
        cfg_write(CFG_BLOCK_SIZE, BLK_SEL_UNUSED);
        cfg_write(CFG_RING_DEPTH, 4'd2);
        cfg_write(CFG_RATE_MODE, 4'(RATE_1PC));
        run_traffic(PHASE_WORDS, 60);

        // Longer blocks; a depth above the slot count must saturate.
        align_ring();
        cfg_write(CFG_BLOCK_SIZE, 4'(BLK_SEL_1536));
        cur_len = BLK_LEN_1;
        cfg_write(CFG_RING_DEPTH, 4'd12);
        cfg_write(CFG_RATE_MODE, 4'(RATE_3PC));
        run_traffic(PHASE_WORDS, 50);

        // Longest blocks with every slot usable.
        align_ring();
        cfg_write(CFG_BLOCK_SIZE, 4'(BLK_SEL_2048));
        cur_len = BLK_LEN_2;
        cfg_write(CFG_RING_DEPTH, 4'd8);
        cfg_write(CFG_RATE_MODE, 4'(RATE_15PC));
        run_traffic(PHASE_WORDS, 50);
        settle();

        // Shorter blocks mid-block, one-slot pacing, and rate control switched off.
        cfg_write(CFG_BLOCK_SIZE, 4'(BLK_SEL_1024));
        cur_len = BLK_LEN_0;
        cfg_write(CFG_RING_DEPTH, 4'd1);
        cfg_write(CFG_RATE_MODE, 4'(RATE_OFF));
        run_traffic(PHASE_WORDS, 45);

        settle();
        if (mismatches == 0) begin
            $display("PASS audio_block_ring_with_rate_control");
        end else begin
            $display("FAIL audio_block_ring_with_rate_control");
        end
        $finish;
    end
endmodule
